// File: rtl/tdm_pkg.sv
// tdm_pkg: shared types, constants and helpers for the tank drive mixer
// no dependencies; used by tank_drive_mixer_with_turn_settle

package tdm_pkg;

  // history depth and derived widths
  localparam int HISTORY_DEPTH = 5;
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

  // configuration port widths
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  // floor(x * 256 / 361) == (x * RECIP_MULT) >> RECIP_SHIFT for x in [0, 32767]
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP_W      = 24;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd11897417;

  // register reset values
  localparam logic [CFG_W-1:0] STRAIGHT_GAIN_RST = 15'd32767;
  localparam logic [CFG_W-1:0] TURN_GAIN_RST     = 15'd32767;
  localparam logic [CFG_W-1:0] DEADZONE_RST      = 15'd2621;
  localparam logic [CFG_W-1:0] TOLERANCE_RST     = 15'd384;
  localparam logic [CFG_W-1:0] MIN_TURN_RST      = 15'd2294;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRAIGHT_GAIN = 3'd0,
    REG_TURN_GAIN     = 3'd1,
    REG_STICK_DZ      = 3'd2,
    REG_TURN_TOL      = 3'd3,
    REG_MIN_TURN      = 3'd4
  } cfg_reg_t;

  // input transaction
  typedef struct packed {
    logic signed [15:0] left_stick;
    logic signed [15:0] right_stick;
    logic               vision_aim;
    logic signed [15:0] aim_offset;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               drive_mode;
    logic               settled;
  } out_t;

  // saturate an 18-bit signed sum to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // magnitude of a 16-bit value known not to be -32768
  function automatic logic [14:0] abs15(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = 16'(-v);
    return v[15] ? neg[14:0] : v[14:0];
  endfunction

endpackage

// File: rtl/tank_drive_mixer_with_turn_settle.sv
// tank_drive_mixer_with_turn_settle: joystick mixer with vision turn-in-place
// depends on tdm_pkg for types, constants and helper functions

// Takes one transaction per cycle while the output is not stalled and returns
// one result per transaction, in order, through one input register and one
// result register, all arithmetic in between. Sticks are mixed into a
// forward and a turning part with their gains unless vision aim is on and both
// sticks are idle; then the block turns in place on the negated aim offset and
// checks a five-entry angle history against the settle tolerance. The history
// survives joystick mode and is never cleared except its fill count at reset.
// Configuration registers may be written only while nothing is in flight.
module tank_drive_mixer_with_turn_settle (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tdm_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tdm_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [tdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int D = tdm_pkg::HISTORY_DEPTH;

  // configuration registers
  logic [tdm_pkg::CFG_W-1:0] straight_gain_r, turn_gain_r, stick_dz_r;
  logic [tdm_pkg::CFG_W-1:0] turn_tol_r, min_turn_r;

  // pipeline registers
  logic          s1_valid_r;
  tdm_pkg::in_t  s1_data_r;
  logic          out_valid_r;
  tdm_pkg::out_t out_data_r;
  tdm_pkg::out_t res_nxt;

  // angle history and fill count
  logic signed [15:0]  hist_r   [D];
  logic signed [15:0]  hist_nxt [D];
  logic [tdm_pkg::FILL_W-1:0] fill_r, fill_nxt;

  logic out_adv, s1_move, turn_mode;

  // handshake
  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      straight_gain_r <= tdm_pkg::STRAIGHT_GAIN_RST;
      turn_gain_r     <= tdm_pkg::TURN_GAIN_RST;
      stick_dz_r      <= tdm_pkg::DEADZONE_RST;
      turn_tol_r      <= tdm_pkg::TOLERANCE_RST;
      min_turn_r      <= tdm_pkg::MIN_TURN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tdm_pkg::REG_STRAIGHT_GAIN: straight_gain_r <= cfg_wdata;
        tdm_pkg::REG_TURN_GAIN:     turn_gain_r     <= cfg_wdata;
        tdm_pkg::REG_STICK_DZ:      stick_dz_r      <= cfg_wdata;
        tdm_pkg::REG_TURN_TOL:      turn_tol_r      <= cfg_wdata;
        tdm_pkg::REG_MIN_TURN:      min_turn_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stick activity
  logic signed [16:0] dz_pos, dz_neg, l_ext, r_ext;
  logic left_act, right_act;
  assign dz_pos    = $signed({2'b00, stick_dz_r});
  assign dz_neg    = -dz_pos;
  assign l_ext     = {s1_data_r.left_stick[15], s1_data_r.left_stick};
  assign r_ext     = {s1_data_r.right_stick[15], s1_data_r.right_stick};
  assign left_act  = (l_ext <= dz_neg) || (l_ext >= dz_pos);
  assign right_act = (r_ext <= dz_neg) || (r_ext >= dz_pos);
  assign turn_mode = s1_data_r.vision_aim && !left_act && !right_act;

  // tank to arcade mixing
  logic signed [16:0] sum_lr, diff_lr, fwd, trn;
  logic signed [32:0] fwd_prod, trn_prod;
  logic signed [17:0] left_mix, right_mix;
  assign sum_lr    = l_ext + r_ext;
  assign diff_lr   = r_ext - l_ext;
  assign fwd_prod  = $signed({1'b0, straight_gain_r}) * sum_lr;
  assign trn_prod  = $signed({1'b0, turn_gain_r}) * diff_lr;
  assign fwd       = fwd_prod[32:16];
  assign trn       = trn_prod[32:16];
  assign left_mix  = {fwd[16], fwd} - {trn[16], trn};
  assign right_mix = {fwd[16], fwd} + {trn[16], trn};

  // negated angle and turn magnitude
  logic signed [15:0] deg;
  logic [14:0] deg_abs, quot;
  logic [tdm_pkg::RECIP_W+14:0] recip_prod;
  logic [15:0] mag_sum;
  logic signed [15:0] mag, mag_neg;
  assign deg        = (s1_data_r.aim_offset == 16'sh8000) ? 16'sh7fff
                                                          : 16'(-s1_data_r.aim_offset);
  assign deg_abs    = tdm_pkg::abs15(deg);
  assign recip_prod = (tdm_pkg::RECIP_W + 15)'(deg_abs) *
                      (tdm_pkg::RECIP_W + 15)'(tdm_pkg::RECIP_MULT);
  assign quot       = recip_prod[tdm_pkg::RECIP_SHIFT +: 15];
  assign mag_sum    = {1'b0, quot} + {1'b0, min_turn_r};
  assign mag        = mag_sum[15] ? 16'sh7fff : $signed(mag_sum);
  assign mag_neg    = -mag;

  // history shift and settle check
  logic outlier;
  always_comb begin
    fill_nxt = (fill_r == tdm_pkg::FILL_W'(D)) ? fill_r : fill_r + 1'b1;
    outlier  = 1'b0;
    for (int i = 0; i < D; i++) begin
      hist_nxt[i] = (i == D - 1) ? deg : hist_r[(i + 1) % D];
      if ((int'(fill_nxt) > D - 1 - i) &&
          ({1'b0, tdm_pkg::abs15(hist_nxt[i])} > {1'b0, turn_tol_r})) begin
        outlier = 1'b1;
      end
    end
  end

  // result select
  always_comb begin
    res_nxt = '0;
    if (!turn_mode) begin
      res_nxt.left_drive  = left_act  ? tdm_pkg::sat16(left_mix)  : 16'sd0;
      res_nxt.right_drive = right_act ? tdm_pkg::sat16(right_mix) : 16'sd0;
    end else begin
      res_nxt.drive_mode = 1'b1;
      if (!outlier) begin
        res_nxt.settled = 1'b1;
      end else if (deg > 16'sd0) begin
        res_nxt.left_drive  = mag_neg;
        res_nxt.right_drive = mag;
      end else begin
        res_nxt.left_drive  = mag;
        res_nxt.right_drive = mag_neg;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move && turn_mode) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= res_nxt;
    end
    if (s1_move && turn_mode) begin
      hist_r <= hist_nxt;
    end
  end

`ifndef SYNTHESIS
  // a settled result is a turn-mode result with both sides at rest
  a_settled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.settled |->
      out_data.drive_mode && out_data.left_drive == 16'sd0 &&
      out_data.right_drive == 16'sd0)
    else $error("settled result with nonzero drive or joystick mode");

  // fill count stays within the history depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= tdm_pkg::FILL_W'(D))
    else $error("history fill count beyond depth");

  // once the history holds an entry it never empties again
  a_fill_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != '0 |=> fill_r != '0)
    else $error("history fill count dropped to zero");

  // an unsettled turn result drives the two sides with mirrored values
  a_turn_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_mode && !out_data.settled |->
      out_data.left_drive == -out_data.right_drive)
    else $error("turn in place without mirrored drive values");
`endif

endmodule

// File: bench/tank_drive_mixer_with_turn_settle_tb.sv
// tank_drive_mixer_with_turn_settle_tb: self-checking bench for the drive mixer
// predicts each result from its own model of the mixer and settle history, except pinned rows
// depends on tdm_pkg and tank_drive_mixer_with_turn_settle only

module tank_drive_mixer_with_turn_settle_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_TICKS   = 205;
  localparam int NUM_PHASES    = 8;
  localparam int DIRECTED_ROWS = 20;

  // index with no register behind it, writes must be dropped
  localparam logic [tdm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum int {SET_RESET, SET_ZERO, SET_MAX, SET_MIXED} settings_t;
  typedef enum int {BURST_SETTLE, BURST_TURN, BURST_JOYSTICK} burst_t;

  // one directed control tick, with a typed-in result where it is obvious
  typedef struct {
    int left;
    int right;
    bit vision;
    int offset;
    bit pinned;
    int want_left;
    int want_right;
    bit want_mode;
    bit want_settled;
  } tick_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  tdm_pkg::in_t                   in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tdm_pkg::out_t                  out_data;
  logic                           cfg_we    = 1'b0;
  logic [tdm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tdm_pkg::CFG_W-1:0]      cfg_wdata = '0;

  // bench copy of the registers
  logic [tdm_pkg::CFG_W-1:0] straight_q = tdm_pkg::STRAIGHT_GAIN_RST;
  logic [tdm_pkg::CFG_W-1:0] turn_q     = tdm_pkg::TURN_GAIN_RST;
  logic [tdm_pkg::CFG_W-1:0] deadzone_q = tdm_pkg::DEADZONE_RST;
  logic [tdm_pkg::CFG_W-1:0] tol_q      = tdm_pkg::TOLERANCE_RST;
  logic [tdm_pkg::CFG_W-1:0] min_turn_q = tdm_pkg::MIN_TURN_RST;

  // bench copy of the angle history
  logic signed [15:0] heading_log [tdm_pkg::HISTORY_DEPTH];
  int                 log_fill = 0;

  tdm_pkg::out_t drive_expected [$];
  int            faults         = 0;
  int            quiet_cycles   = 0;
  int            send_gap_pct   = 0;
  int            recv_stall_pct = 0;
  bit            pin_active     = 1'b0;
  tdm_pkg::out_t pin_result     = '0;

  settings_t  phase_settings [NUM_PHASES] = '{SET_MIXED, SET_MAX, SET_ZERO, SET_MIXED,
                                              SET_RESET, SET_MIXED, SET_MIXED, SET_MIXED};
  idle_mode_t phase_idle [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                          IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};

  // directed ticks, run with the reset register values
  tick_row_t plan [DIRECTED_ROWS] = '{
    // both sticks quiet, vision off: nothing drives
    '{     0,      0, 1'b0,      0, 1'b1,    0,     0, 1'b0, 1'b0},
    // stick extremes through the mixer
    '{ 32767,  32767, 1'b0,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    '{-32768, -32768, 1'b0,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    '{ 32767, -32768, 1'b0,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    // vision on but sticks active keeps joystick mode
    '{-32768,  32767, 1'b1,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    // first turn sample already inside tolerance
    '{     0,      0, 1'b1,      0, 1'b1,    0,     0, 1'b1, 1'b1},
    // most negative offset saturates when negated, then the opposite extreme
    '{     0,      0, 1'b1, -32768, 1'b0,    0,     0, 1'b0, 1'b0},
    '{     0,      0, 1'b1,  32767, 1'b0,    0,     0, 1'b0, 1'b0},
    // zero angle while outliers remain: only the minimum drive
    '{     0,      0, 1'b1,      0, 1'b1, 2294, -2294, 1'b1, 1'b0},
    '{     0,      0, 1'b1,      0, 1'b1, 2294, -2294, 1'b1, 1'b0},
    '{     0,      0, 1'b1,      0, 1'b1, 2294, -2294, 1'b1, 1'b0},
    '{     0,      0, 1'b1,      0, 1'b1, 2294, -2294, 1'b1, 1'b0},
    // outliers flushed out of the history
    '{     0,      0, 1'b1,      0, 1'b1,    0,     0, 1'b1, 1'b1},
    // angle exactly at the tolerance, then one past it
    '{     0,      0, 1'b1,   -384, 1'b1,    0,     0, 1'b1, 1'b1},
    '{     0,      0, 1'b1,   -385, 1'b0,    0,     0, 1'b0, 1'b0},
    // sticks exactly at the deadzone are active
    '{  2621,      0, 1'b1,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    '{ -2621,      0, 1'b1,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    // just inside the deadzone turns in place, history kept across joystick ticks
    '{  2620,  -2620, 1'b1,      0, 1'b0,    0,     0, 1'b0, 1'b0},
    '{   100,   -100, 1'b0,      0, 1'b1,    0,     0, 1'b0, 1'b0},
    // only one side active
    '{     0,  32767, 1'b0,      0, 1'b0,    0,     0, 1'b0, 1'b0}
  };

  tank_drive_mixer_with_turn_settle DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // expected drive for one tick; advances the bench angle history on turn ticks
  function automatic tdm_pkg::out_t compute_drive(tdm_pkg::in_t x);
    int                 l, r, off, dz, mag_a, i;
    bit                 l_on, r_on, outlier;
    longint             fwd, rot;
    logic signed [15:0] heading, mag;
    tdm_pkg::out_t      res;
    res = '0;
    l = $signed(x.left_stick);
    r = $signed(x.right_stick);
    off = $signed(x.aim_offset);
    dz = int'(deadzone_q);
    l_on = (l <= -dz) || (l >= dz);
    r_on = (r <= -dz) || (r >= dz);
    if (l_on || r_on || !x.vision_aim) begin
      // tank to arcade mix, floor of the products with the gains in Q0.16
      fwd = (longint'(straight_q) * longint'(l + r)) >>> 16;
      rot = (longint'(turn_q) * longint'(r - l)) >>> 16;
      if (l_on) res.left_drive = clamp16(fwd - rot);
      if (r_on) res.right_drive = clamp16(fwd + rot);
    end else begin
      res.drive_mode = 1'b1;
      heading = clamp16(-longint'(off));
      for (i = 0; i < tdm_pkg::HISTORY_DEPTH - 1; i++) heading_log[i] = heading_log[i + 1];
      heading_log[tdm_pkg::HISTORY_DEPTH - 1] = heading;
      if (log_fill < tdm_pkg::HISTORY_DEPTH) log_fill++;
      outlier = 1'b0;
      for (i = tdm_pkg::HISTORY_DEPTH - log_fill; i < tdm_pkg::HISTORY_DEPTH; i++) begin
        mag_a = $signed(heading_log[i]);
        if (mag_a < 0) mag_a = -mag_a;
        if (mag_a > int'(tol_q)) outlier = 1'b1;
      end
      if (!outlier) begin
        res.settled = 1'b1;
      end else begin
        mag_a = $signed(heading);
        if (mag_a < 0) mag_a = -mag_a;
        mag = clamp16(longint'(mag_a) * 256 / 361 + longint'(min_turn_q));
        if (heading > 0) begin
          res.left_drive  = -mag;
          res.right_drive = mag;
        end else begin
          res.left_drive  = mag;
          res.right_drive = -mag;
        end
      end
    end
    return res;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  // result check first, then prediction of the transaction taken at this edge
  always @(posedge clk) begin
    tdm_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (drive_expected.size() == 0) begin
          $error("result %h with no transaction outstanding", out_data);
          faults++;
        end else begin
          want = drive_expected[0];
          drive_expected.delete(0);
          compare_field("left_drive", $signed(want.left_drive), $signed(out_data.left_drive));
          compare_field("right_drive", $signed(want.right_drive),
                        $signed(out_data.right_drive));
          compare_field("drive_mode", want.drive_mode, out_data.drive_mode);
          compare_field("settled", want.settled, out_data.settled);
        end
      end
      if (in_valid && !in_stall) begin
        want = compute_drive(in_data);
        if (pin_active) want = pin_result;
        drive_expected = {drive_expected, want};
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 66; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 66; end
      default:   begin send_gap_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  // entered and left at a falling edge with in_valid low
  task automatic send_tick(tdm_pkg::in_t x, bit pinned, tdm_pkg::out_t fixed);
    while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk);
    in_data    = x;
    pin_active = pinned;
    pin_result = fixed;
    in_valid   = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (drive_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [tdm_pkg::CFG_IDX_W-1:0] idx,
                           logic [tdm_pkg::CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      tdm_pkg::REG_STRAIGHT_GAIN: straight_q = value;
      tdm_pkg::REG_TURN_GAIN:     turn_q     = value;
      tdm_pkg::REG_STICK_DZ:      deadzone_q = value;
      tdm_pkg::REG_TURN_TOL:      tol_q      = value;
      tdm_pkg::REG_MIN_TURN:      min_turn_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // narrow settings keep some mixed draws of deadzone and tolerance where turning is reachable
  function automatic logic [tdm_pkg::CFG_W-1:0] draw_setting(settings_t kind, bit narrow);
    case (kind)
      SET_ZERO: return '0;
      SET_MAX:  return 15'h7fff;
      default: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return 15'h7fff;
          2, 3:    return narrow ? 15'($urandom_range(1, 3000)) : 15'($urandom);
          default: return 15'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic load_settings(settings_t kind);
    if (kind == SET_RESET) begin
      write_reg(tdm_pkg::REG_STRAIGHT_GAIN, tdm_pkg::STRAIGHT_GAIN_RST);
      write_reg(tdm_pkg::REG_TURN_GAIN, tdm_pkg::TURN_GAIN_RST);
      write_reg(tdm_pkg::REG_STICK_DZ, tdm_pkg::DEADZONE_RST);
      write_reg(tdm_pkg::REG_TURN_TOL, tdm_pkg::TOLERANCE_RST);
      write_reg(tdm_pkg::REG_MIN_TURN, tdm_pkg::MIN_TURN_RST);
    end else begin
      write_reg(tdm_pkg::REG_STRAIGHT_GAIN, draw_setting(kind, 1'b0));
      write_reg(tdm_pkg::REG_TURN_GAIN, draw_setting(kind, 1'b0));
      write_reg(tdm_pkg::REG_STICK_DZ, draw_setting(kind, 1'b1));
      write_reg(tdm_pkg::REG_TURN_TOL, draw_setting(kind, 1'b1));
      write_reg(tdm_pkg::REG_MIN_TURN, draw_setting(kind, 1'b0));
    end
    // a write to an unmapped index must change nothing
    write_reg(REG_UNMAPPED, 15'($urandom));
  endtask

  // stick value strictly inside the deadzone, or anything when there is none
  function automatic logic signed [15:0] quiet_stick();
    int span, v;
    span = int'(deadzone_q) - 1;
    if (span < 0) return 16'($urandom);
    v = $urandom_range(0, span);
    if ($urandom_range(0, 1)) v = -v;
    return 16'(v);
  endfunction

  // offset whose negation lies within +-limit
  function automatic logic signed [15:0] offset_within(int limit);
    int v;
    v = $urandom_range(0, limit);
    if ($urandom_range(0, 1)) v = -v;
    return 16'(v);
  endfunction

  function automatic tdm_pkg::in_t make_tick(burst_t kind);
    tdm_pkg::in_t x;
    int           reach;
    x = '0;
    case (kind)
      BURST_SETTLE: begin
        x.left_stick  = quiet_stick();
        x.right_stick = quiet_stick();
        x.vision_aim  = 1'b1;
        x.aim_offset  = offset_within(int'(tol_q));
      end
      BURST_TURN: begin
        x.left_stick  = quiet_stick();
        x.right_stick = quiet_stick();
        x.vision_aim  = 1'b1;
        reach = 2 * int'(tol_q) + 16;
        if (reach > 32767) reach = 32767;
        x.aim_offset  = $urandom_range(0, 1) ? 16'($urandom) : offset_within(reach);
      end
      default: begin
        x.left_stick  = $urandom_range(0, 3) == 0 ? quiet_stick() : 16'($urandom);
        x.right_stick = $urandom_range(0, 3) == 0 ? quiet_stick() : 16'($urandom);
        x.vision_aim  = 1'($urandom_range(0, 1));
        x.aim_offset  = 16'($urandom);
      end
    endcase
    return x;
  endfunction

  initial begin
    tdm_pkg::in_t  tick;
    tdm_pkg::out_t fixed;
    burst_t        kind;
    int            sent, run, pick;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (plan[i]) begin
      tick.left_stick    = 16'(plan[i].left);
      tick.right_stick   = 16'(plan[i].right);
      tick.vision_aim    = plan[i].vision;
      tick.aim_offset    = 16'(plan[i].offset);
      fixed.left_drive   = 16'(plan[i].want_left);
      fixed.right_drive  = 16'(plan[i].want_right);
      fixed.drive_mode   = plan[i].want_mode;
      fixed.settled      = plan[i].want_settled;
      send_tick(tick, plan[i].pinned, fixed);
    end

    // random phases, each with its own register settings and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      load_settings(phase_settings[p]);
      set_idle(phase_idle[p]);
      sent = 0;
      while (sent < PHASE_TICKS) begin
        pick = $urandom_range(0, 99);
        kind = pick < 35 ? BURST_SETTLE : (pick < 55 ? BURST_TURN : BURST_JOYSTICK);
        run = $urandom_range(1, 9);
        repeat (run) begin
          send_tick(make_tick(kind), 1'b0, '0);
          sent++;
        end
        // occasionally hold off until the pipeline is empty
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    if (faults == 0 && drive_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
